// ===== hw/rtl/lbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the LED blink controller.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int unsigned TickWidthDef = 16;
  localparam int unsigned ReqW         = 3;
  localparam int unsigned LenInW       = 16;
  localparam int unsigned CntW         = 8;
  localparam int unsigned ModeW        = 2;

  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK           = 3'd0,
    REQ_FORCE_ON       = 3'd1,
    REQ_FORCE_OFF      = 3'd2,
    REQ_BLINK          = 3'd3,
    REQ_BLINK_STOP_ON  = 3'd4,
    REQ_BLINK_STOP_OFF = 3'd5
  } req_e;

  typedef enum logic [ModeW-1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STOP_NONE = 2'd0,
    STOP_ON   = 2'd1,
    STOP_OFF  = 2'd2
  } stop_e;

endpackage

// ===== hw/rtl/led_blink_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_controller_unit
// Drives one LED from a stream of tick and command items.
// ----------------------------------------------------------------------------
// Takes one item per clock while not stalled and returns one result (LED level
// and mode) per item: the item is captured in an input register, and when it
// advances the blink state is updated and the result is latched into the output
// register in the same cycle. The input side stalls only while both the
// input register and a held result are full and the output is stalled.
module led_blink_controller_unit #(
  parameter int unsigned TICK_WIDTH = lbc_pkg::TickWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lbc_pkg::ReqW-1:0]      req_type_i,
  input  logic [lbc_pkg::LenInW-1:0]    on_ticks_i,
  input  logic [lbc_pkg::LenInW-1:0]    off_ticks_i,
  input  logic [lbc_pkg::CntW-1:0]      stop_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          led_level_o,
  output logic [lbc_pkg::ModeW-1:0]     led_mode_o
);

  logic                       in_valid_q, in_valid_d;
  logic [lbc_pkg::ReqW-1:0]   req_q;
  logic [lbc_pkg::LenInW-1:0] on_q;
  logic [lbc_pkg::LenInW-1:0] off_q;
  logic [lbc_pkg::CntW-1:0]   cnt_q;
  logic                       out_valid_q, out_valid_d;
  logic                       level_q;
  lbc_pkg::mode_e             mode_q;
  logic                       accept;
  logic                       adv;
  logic                       core_level;
  lbc_pkg::mode_e             core_mode;

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_valid_d  = accept ? 1'b1 : (adv ? 1'b0 : in_valid_q);
  assign out_valid_d = adv ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      on_q  <= on_ticks_i;
      off_q <= off_ticks_i;
      cnt_q <= stop_count_i;
    end
    if (adv) begin
      level_q <= core_level;
      mode_q  <= core_mode;
    end
  end

  lbc_core #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .req_type_i  (req_q),
    .on_ticks_i  (on_q),
    .off_ticks_i (off_q),
    .stop_count_i(cnt_q),
    .led_level_o (core_level),
    .led_mode_o  (core_mode)
  );

  assign out_valid_o = out_valid_q;
  assign led_level_o = level_q;
  assign led_mode_o  = mode_q;

`ifndef ASSERT_OFF
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_force_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (req_q == lbc_pkg::REQ_FORCE_ON) |=>
      led_level_o && (led_mode_o == lbc_pkg::MODE_ON))
    else $error("force on did not light the LED");

  a_blink_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && ((req_q == lbc_pkg::REQ_BLINK) || (req_q == lbc_pkg::REQ_BLINK_STOP_ON) ||
            (req_q == lbc_pkg::REQ_BLINK_STOP_OFF)) |=>
      out_valid_o && (led_mode_o == lbc_pkg::MODE_BLINK))
    else $error("blink command did not enter blink mode");
`endif

endmodule

// ===== hw/rtl/lbc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_core
// Blink state and its update for one item, applied while enabled.
// ----------------------------------------------------------------------------
module lbc_core #(
  parameter int unsigned TICK_WIDTH = lbc_pkg::TickWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [lbc_pkg::ReqW-1:0]      req_type_i,
  input  logic [lbc_pkg::LenInW-1:0]    on_ticks_i,
  input  logic [lbc_pkg::LenInW-1:0]    off_ticks_i,
  input  logic [lbc_pkg::CntW-1:0]      stop_count_i,
  output logic                          led_level_o,
  output lbc_pkg::mode_e                led_mode_o
);

  lbc_pkg::mode_e              mode_q, mode_d;
  lbc_pkg::stop_e              stop_sel_q, stop_sel_d;
  logic                        level_q, level_d;
  logic [TICK_WIDTH-1:0]       tick_cnt_q, tick_cnt_d;
  logic [TICK_WIDTH-1:0]       phase_len_q, phase_len_d;
  logic [TICK_WIDTH-1:0]       on_len_q, on_len_d;
  logic [TICK_WIDTH-1:0]       off_len_q, off_len_d;
  logic [lbc_pkg::CntW-1:0]    tog_cnt_q, tog_cnt_d;
  logic [lbc_pkg::CntW-1:0]    tog_lim_q, tog_lim_d;

  logic [TICK_WIDTH-1:0]       tick_inc;
  logic [TICK_WIDTH-1:0]       on_in, off_in;
  logic                        tog_counts;
  logic [lbc_pkg::CntW-1:0]    tog_next;

  assign tick_inc   = tick_cnt_q + 1'b1;
  assign on_in      = TICK_WIDTH'(on_ticks_i);
  assign off_in     = TICK_WIDTH'(off_ticks_i);
  assign tog_counts = level_q ? (stop_sel_q == lbc_pkg::STOP_OFF)
                              : (stop_sel_q == lbc_pkg::STOP_ON);
  assign tog_next   = (tog_counts && (tog_cnt_q != lbc_pkg::CntMax)) ?
                      tog_cnt_q + 1'b1 : tog_cnt_q;

  always_comb begin
    mode_d      = mode_q;
    stop_sel_d  = stop_sel_q;
    level_d     = level_q;
    tick_cnt_d  = tick_cnt_q;
    phase_len_d = phase_len_q;
    on_len_d    = on_len_q;
    off_len_d   = off_len_q;
    tog_cnt_d   = tog_cnt_q;
    tog_lim_d   = tog_lim_q;
    unique case (lbc_pkg::req_e'(req_type_i)) inside
      lbc_pkg::REQ_TICK: begin
        if (mode_q == lbc_pkg::MODE_BLINK) begin
          if (tick_inc >= phase_len_q) begin
            phase_len_d = level_q ? off_len_q : on_len_q;
            level_d     = ~level_q;
            tick_cnt_d  = '0;
            tog_cnt_d   = tog_next;
            if (stop_sel_q != lbc_pkg::STOP_NONE && tog_next >= tog_lim_q) begin
              mode_d = (stop_sel_q == lbc_pkg::STOP_OFF) ? lbc_pkg::MODE_OFF
                                                         : lbc_pkg::MODE_ON;
            end
          end else begin
            tick_cnt_d = tick_inc;
          end
        end
      end
      lbc_pkg::REQ_FORCE_ON: begin
        level_d = 1'b1;
        mode_d  = lbc_pkg::MODE_ON;
      end
      lbc_pkg::REQ_FORCE_OFF: begin
        level_d = 1'b0;
        mode_d  = lbc_pkg::MODE_OFF;
      end
      lbc_pkg::REQ_BLINK, lbc_pkg::REQ_BLINK_STOP_ON, lbc_pkg::REQ_BLINK_STOP_OFF: begin
        mode_d      = lbc_pkg::MODE_BLINK;
        on_len_d    = on_in;
        off_len_d   = off_in;
        tog_cnt_d   = '0;
        tick_cnt_d  = '0;
        phase_len_d = level_q ? on_in : off_in;
        if (lbc_pkg::req_e'(req_type_i) == lbc_pkg::REQ_BLINK) begin
          stop_sel_d = lbc_pkg::STOP_NONE;
          tog_lim_d  = '0;
        end else begin
          stop_sel_d = (lbc_pkg::req_e'(req_type_i) == lbc_pkg::REQ_BLINK_STOP_ON) ?
                       lbc_pkg::STOP_ON : lbc_pkg::STOP_OFF;
          tog_lim_d  = stop_count_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= lbc_pkg::MODE_OFF;
      stop_sel_q  <= lbc_pkg::STOP_NONE;
      level_q     <= 1'b0;
      tick_cnt_q  <= '0;
      phase_len_q <= '0;
      on_len_q    <= '0;
      off_len_q   <= '0;
      tog_cnt_q   <= '0;
      tog_lim_q   <= '0;
    end else if (en_i) begin
      mode_q      <= mode_d;
      stop_sel_q  <= stop_sel_d;
      level_q     <= level_d;
      tick_cnt_q  <= tick_cnt_d;
      phase_len_q <= phase_len_d;
      on_len_q    <= on_len_d;
      off_len_q   <= off_len_d;
      tog_cnt_q   <= tog_cnt_d;
      tog_lim_q   <= tog_lim_d;
    end
  end

  // result reflects the state after this item
  assign led_level_o = level_d;
  assign led_mode_o  = mode_d;

endmodule
